// ===== rtl/rmfw_pkg.sv =====
// rmfw_pkg: shared types, widths, register codes and defaults of the rgb median filter
// no dependencies

package rmfw_pkg;

   // parameter defaults
   localparam int KERNEL_W_DEF  = 3;
   localparam int KERNEL_H_DEF  = 3;
   localparam int MAX_WIDTH_DEF = 2048;

   // pixel layout
   localparam int CH_W     = 8;
   localparam int NUM_CH   = 3;
   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;

   // frame geometry
   localparam int ROW_W   = 16;
   localparam int IMG_W_W = 12;
   localparam int IMG_H_W = 16;

   // control and status registers
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);
   localparam logic [IMG_W_W-1:0]   IMAGE_WIDTH_RST  = IMG_W_W'(640);
   localparam logic [IMG_H_W-1:0]   IMAGE_HEIGHT_RST = IMG_H_W'(480);

   typedef logic [CH_W-1:0]          chan_type;
   typedef chan_type [NUM_CH-1:0]    pix_type;
   typedef logic [ROW_W-1:0]         row_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]    csr_data_type;

endpackage

// ===== rtl/rmfw_ifs.sv =====
// rmfw_ifs: valid/ready channel interfaces for pixel input, filtered output and registers
// depends on rmfw_pkg

interface rmfw_req_if import rmfw_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type in_blue;
   chan_type in_green;
   chan_type in_red;

   modport source (output valid, in_blue, in_green, in_red, input ready);
   modport sink   (input valid, in_blue, in_green, in_red, output ready);
endinterface

interface rmfw_rsp_if import rmfw_pkg::*; #(
   parameter int COL_W = $clog2(MAX_WIDTH_DEF)
) ();
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] out_col;
   row_type          out_row;
   chan_type         out_blue;
   chan_type         out_green;
   chan_type         out_red;

   modport source (output valid, out_col, out_row, out_blue, out_green, out_red,
                   input ready);
   modport sink   (input valid, out_col, out_row, out_blue, out_green, out_red,
                   output ready);
endinterface

interface rmfw_csr_if import rmfw_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rmfw_front.sv =====
// rmfw_front: raster counters, size registers, line memories and the pixel window
// depends on rmfw_pkg

module rmfw_front import rmfw_pkg::*; #(
   parameter int KERNEL_W  = KERNEL_W_DEF,
   parameter int KERNEL_H  = KERNEL_H_DEF,
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   localparam int HALF_W   = KERNEL_W / 2,
   localparam int HALF_H   = KERNEL_H / 2,
   localparam int WIN_W    = 2 * HALF_W + 1,
   localparam int WIN_H    = 2 * HALF_H + 1,
   localparam int WIN_N    = WIN_W * WIN_H,
   localparam int COL_W    = $clog2(MAX_WIDTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  csr_idx_type            csr_index,
   input  csr_data_type           csr_data,
   input  logic                   req_valid,
   input  pix_type                req_pix,
   output logic                   req_ready,
   output logic                   win_valid,
   input  logic                   win_ready,
   output pix_type [WIN_N-1:0]    win_data,
   output logic [COL_W-1:0]       win_col,
   output row_type                win_row
);

   localparam int LINES   = WIN_H - 1;
   localparam int LINES_D = (LINES > 0) ? LINES : 1;
   localparam int WCMP_W  = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;

   logic [IMG_W_W-1:0] width_ff, width_in;
   logic [IMG_H_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]   col_ff, col_in;
   row_type            row_ff, row_in;

   logic               s1_valid_ff;
   pix_type            s1_pix_ff;
   logic [COL_W-1:0]   s1_col_ff;
   row_type            s1_row_ff;

   logic               csr_hit, req_fire, s1_fire, s1_emit;
   logic               last_col, last_row;
   logic [WCMP_W-1:0]  w_ext, w_eff, col_next;
   logic [IMG_H_W-1:0] h_eff;
   logic [ROW_W:0]     row_next;

   pix_type            line_q  [LINES_D];
   pix_type            line_wd [LINES_D];
   pix_type            colv    [WIN_H];
   pix_type            win_ff  [WIN_H][WIN_W];
   pix_type            win_in  [WIN_H][WIN_W];

   // register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      csr_hit   = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_data[IMG_W_W-1:0];
               csr_hit  = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_data[IMG_H_W-1:0];
               csr_hit   = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   // raster position
   always_comb begin
      w_ext = WCMP_W'(width_ff);
      if (w_ext == '0) begin
         w_eff = WCMP_W'(1);
      end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
         w_eff = WCMP_W'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      col_next = WCMP_W'(col_ff) + WCMP_W'(1);
      last_col = col_next >= w_eff;
      h_eff    = (height_ff == '0) ? IMG_H_W'(1) : height_ff;
      row_next = (ROW_W + 1)'(row_ff) + (ROW_W + 1)'(1);
      last_row = row_next >= (ROW_W + 1)'(h_eff);

      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RST;
         height_ff <= IMAGE_HEIGHT_RST;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // holding stage, line read data lines up with it
   assign s1_emit   = (s1_col_ff >= COL_W'(2 * HALF_W)) && (s1_row_ff >= ROW_W'(2 * HALF_H));
   assign s1_fire   = s1_valid_ff && (!s1_emit || win_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff <= req_pix;
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
      end
   end

   // line memories: line k holds the row k+1 above the current one
   always_comb begin
      line_wd[0] = s1_pix_ff;
      for (int k = 1; k < LINES; k++) begin
         line_wd[k] = line_q[k-1];
      end
   end

   for (genvar k = 0; k < LINES; k++) begin : g_line
      pix_type mem [MAX_WIDTH];
      pix_type rd_ff;
      pix_type byp_data_ff;
      logic    byp_ff;

      always_ff @(posedge clock) begin
         if (s1_fire) begin
            mem[s1_col_ff] <= line_wd[k];
         end
         if (req_fire) begin
            rd_ff       <= mem[col_ff];
            byp_ff      <= s1_fire && (s1_col_ff == col_ff);
            byp_data_ff <= line_wd[k];
         end
      end

      assign line_q[k] = byp_ff ? byp_data_ff : rd_ff;
   end

   if (LINES == 0) begin : g_no_line
      assign line_q[0] = s1_pix_ff;
   end

   // window shift, oldest row on top
   always_comb begin
      colv[WIN_H-1] = s1_pix_ff;
      for (int k = 0; k < LINES; k++) begin
         colv[WIN_H-2-k] = line_q[k];
      end
      for (int y = 0; y < WIN_H; y++) begin
         for (int x = 0; x < WIN_W - 1; x++) begin
            win_in[y][x] = win_ff[y][x+1];
         end
         win_in[y][WIN_W-1] = colv[y];
      end
      for (int y = 0; y < WIN_H; y++) begin
         for (int x = 0; x < WIN_W; x++) begin
            win_data[y*WIN_W + x] = win_in[y][x];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         win_ff <= win_in;
      end
   end

   assign win_valid = s1_valid_ff && s1_emit;
   assign win_col   = s1_col_ff - COL_W'(HALF_W);
   assign win_row   = s1_row_ff - ROW_W'(HALF_H);

`ifndef NO_ASSERTIONS
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> col_ff == '0 && row_ff == '0)
      else $error("register write did not restart the frame");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && !last_col && !csr_hit |=> col_ff == COL_W'($past(col_ff) + COL_W'(1)))
      else $error("column counter did not advance");

   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_col_ff) && $stable(s1_row_ff))
      else $error("stalled pixel lost its position");
`endif

endmodule

// ===== rtl/rmfw_sort_cell.sv =====
// rmfw_sort_cell: one insertion step of the median sorter chain, per channel
// depends on rmfw_pkg

module rmfw_sort_cell import rmfw_pkg::*; #(
   parameter int WIN_N = 9,
   parameter int STEP  = 0,
   parameter int COL_W = $clog2(MAX_WIDTH_DEF)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  pix_type [WIN_N-1:0]                 in_win,
   input  chan_type [NUM_CH-1:0][WIN_N-1:0]    in_srt,
   input  logic [COL_W-1:0]                    in_col,
   input  row_type                             in_row,
   output logic                                out_valid,
   input  logic                                out_ready,
   output pix_type [WIN_N-1:0]                 out_win,
   output chan_type [NUM_CH-1:0][WIN_N-1:0]    out_srt,
   output logic [COL_W-1:0]                    out_col,
   output row_type                             out_row
);

   logic                              valid_ff;
   pix_type [WIN_N-1:0]               win_ff;
   chan_type [NUM_CH-1:0][WIN_N-1:0]  srt_ff, srt_in;
   logic [COL_W-1:0]                  col_ff;
   row_type                           row_ff;

   chan_type                          ins_val, prev_val;
   logic                              cur_gt, prev_gt;
   logic                              ordered;

   // insert window value STEP into the sorted prefix of length STEP
   always_comb begin
      srt_in = in_srt;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         ins_val  = in_win[STEP][ch];
         prev_gt  = 1'b0;
         prev_val = '0;
         for (int j = 0; j < WIN_N; j++) begin
            cur_gt = (j < STEP) && (in_srt[ch][j] > ins_val);
            if ((j < STEP) && !cur_gt) begin
               srt_in[ch][j] = in_srt[ch][j];
            end else if (!prev_gt) begin
               srt_in[ch][j] = ins_val;
            end else begin
               srt_in[ch][j] = prev_val;
            end
            prev_gt  = cur_gt;
            prev_val = in_srt[ch][j];
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         win_ff <= in_win;
         srt_ff <= srt_in;
         col_ff <= in_col;
         row_ff <= in_row;
      end
   end

   assign out_valid = valid_ff;
   assign out_win   = win_ff;
   assign out_srt   = srt_ff;
   assign out_col   = col_ff;
   assign out_row   = row_ff;

   // sorted prefix check
   always_comb begin
      ordered = 1'b1;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int j = 1; j <= STEP; j++) begin
            if (srt_ff[ch][j-1] > srt_ff[ch][j]) begin
               ordered = 1'b0;
            end
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_prefix_sorted: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ordered)
      else $error("sorter cell holds an unordered prefix");
`endif

endmodule

// ===== rtl/rgb_median_filter_window.sv =====
// rgb_median_filter_window: top level of the streaming rgb median filter
// depends on rmfw_pkg, rmfw_ifs, rmfw_front, rmfw_sort_cell

// usage
// - req_ch takes one rgb pixel per cycle unless stalled, raster order, left to right, top down
// - rsp_ch gives one item per interior centre pixel: its column, row and the per
//   channel median of the window around it; border pixels give no item
// - csr_ch writes image_width (index 0) and image_height (index 1); a write to either
//   restarts the frame at column 0, row 0; write only while no item is in flight
// - path: the pixel that completes a window passes the holding stage and then every
//   sorter cell before its result leaves
// - throughput: one pixel per cycle while rsp_ch is not stalled; the sorter is a
//   chain of window-size insertion cells, one window value inserted per cell, and
//   the line memories take one read and one write per cycle
// - a stalled rsp_ch fills the chain cell by cell from the output end; bubbles
//   close up, so req_ch.ready drops only once the whole chain is full
// - reset sets the size registers to 640 by 480 and the raster position to zero;
//   line memory content is not cleared, and no result is built from a line entry
//   that its own frame has not written
module rgb_median_filter_window import rmfw_pkg::*; #(
   parameter int KERNEL_W  = KERNEL_W_DEF,
   parameter int KERNEL_H  = KERNEL_H_DEF,
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   rmfw_req_if.sink      req_ch,
   rmfw_rsp_if.source    rsp_ch,
   rmfw_csr_if.sink      csr_ch
);

   localparam int HALF_W = KERNEL_W / 2;
   localparam int HALF_H = KERNEL_H / 2;
   localparam int WIN_N  = (2 * HALF_W + 1) * (2 * HALF_H + 1);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int MID    = WIN_N / 2;

   pix_type                          req_pix;

   // sorter chain links, link 0 feeds the first cell
   logic [WIN_N:0]                   chain_valid;
   logic [WIN_N:0]                   chain_ready;
   pix_type [WIN_N-1:0]              chain_win [WIN_N+1];
   chan_type [NUM_CH-1:0][WIN_N-1:0] chain_srt [WIN_N+1];
   logic [COL_W-1:0]                 chain_col [WIN_N+1];
   row_type                          chain_row [WIN_N+1];

   // register writes are never stalled
   assign csr_ch.ready = 1'b1;

   assign req_pix[CH_BLUE]  = req_ch.in_blue;
   assign req_pix[CH_GREEN] = req_ch.in_green;
   assign req_pix[CH_RED]   = req_ch.in_red;

   // counters, line memories and window
   rmfw_front #(
      .KERNEL_W  (KERNEL_W),
      .KERNEL_H  (KERNEL_H),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .req_valid (req_ch.valid),
      .req_pix   (req_pix),
      .req_ready (req_ch.ready),
      .win_valid (chain_valid[0]),
      .win_ready (chain_ready[0]),
      .win_data  (chain_win[0]),
      .win_col   (chain_col[0]),
      .win_row   (chain_row[0])
   );

   // sorted lists start empty
   assign chain_srt[0] = '0;

   // insertion sorter chain, the last cell is the output register
   for (genvar i = 0; i < WIN_N; i++) begin : g_cell
      rmfw_sort_cell #(
         .WIN_N (WIN_N),
         .STEP  (i),
         .COL_W (COL_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_win    (chain_win[i]),
         .in_srt    (chain_srt[i]),
         .in_col    (chain_col[i]),
         .in_row    (chain_row[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_win   (chain_win[i+1]),
         .out_srt   (chain_srt[i+1]),
         .out_col   (chain_col[i+1]),
         .out_row   (chain_row[i+1])
      );
   end

   // median is the middle entry of each fully sorted channel
   assign rsp_ch.valid          = chain_valid[WIN_N];
   assign chain_ready[WIN_N]    = rsp_ch.ready;
   assign rsp_ch.out_col        = chain_col[WIN_N];
   assign rsp_ch.out_row        = chain_row[WIN_N];
   assign rsp_ch.out_blue       = chain_srt[WIN_N][CH_BLUE][MID];
   assign rsp_ch.out_green      = chain_srt[WIN_N][CH_GREEN][MID];
   assign rsp_ch.out_red        = chain_srt[WIN_N][CH_RED][MID];

`ifndef NO_ASSERTIONS
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.out_col >= COL_W'(HALF_W) && rsp_ch.out_row >= ROW_W'(HALF_H))
      else $error("result item for a border pixel");
`endif

endmodule

// ===== dv/tb_rgb_median_filter_window.sv =====
// self-checking bench for rgb_median_filter_window: streams raster pixels over many frame
// geometries and checks every windowed median against an in-bench predictor
// depends on rmfw_pkg, rmfw_ifs and the rtl of rgb_median_filter_window
`timescale 1ns / 1ps

module tb_rgb_median_filter_window;
   import rmfw_pkg::*;

   // window geometry follows the block defaults; even kernels grow to the next odd size
   localparam int HALF_W = KERNEL_W_DEF / 2;
   localparam int HALF_H = KERNEL_H_DEF / 2;
   localparam int WIN_W  = 2 * HALF_W + 1;
   localparam int WIN_H  = 2 * HALF_H + 1;
   localparam int WIN_N  = WIN_W * WIN_H;
   localparam int MAX_W  = MAX_WIDTH_DEF;
   localparam int COL_W  = $clog2(MAX_W);

   // let the holding stage and the sorter chain run dry before touching registers
   localparam int DRAIN_CYCLES = 3 * (WIN_N + 1);
   localparam int SWEEP_PIXELS = 250;
   localparam int CALM_PIXELS  = 100;
   localparam int MAX_REPORTS  = 40;

   // register slots past the end of the list; writes there must do nothing
   localparam csr_idx_type CSR_SPARE_A = CSR_IDX_W'(2);
   localparam csr_idx_type CSR_SPARE_B = CSR_IDX_W'(3);

   typedef struct packed {
      logic [COL_W-1:0] col;
      row_type          row;
      chan_type         blue;
      chan_type         green;
      chan_type         red;
   } median_type;

   logic clock;
   logic reset;

   rmfw_req_if                  req_if();
   rmfw_rsp_if #(.COL_W(COL_W)) rsp_if();
   rmfw_csr_if                  csr_if();

   rgb_median_filter_window #(
      .KERNEL_W (KERNEL_W_DEF),
      .KERNEL_H (KERNEL_H_DEF),
      .MAX_WIDTH(MAX_WIDTH_DEF)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_ch(csr_if)
   );

   // predictor state: line rows, window, raster position and frame size
   pix_type            line_mem [WIN_H-1][MAX_W];
   pix_type            win_px [WIN_H][WIN_W];
   logic [IMG_W_W-1:0] geo_width;
   logic [IMG_H_W-1:0] geo_height;
   int unsigned        col_pos;
   int unsigned        row_pos;

   pix_type    pixel_queue[$];    // pixels waiting to be driven
   median_type median_queue[$];   // medians predicted, not yet seen

   bit feed_idle;                 // sender may insert gaps
   bit drain_idle;                // receiver may stall
   int gap_left;
   int stall_left;
   int errors;
   int pixels_taken;
   int medians_seen;
   int regs_written;
   int geometries;

   // corner values for the head of the first row: all-zero, all-one, single channels,
   // alternating bits, mid-scale neighbors
   pix_type corner_px [20] = '{
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'hAA55AA, 24'h55AA55, 24'h808080, 24'h7F7F7F, 24'h010101,
      24'hFEFEFE, 24'h000000, 24'hFFFFFF, 24'h0F0F0F, 24'hF0F0F0,
      24'h80007F, 24'h7F0080, 24'h123456, 24'hFEDCBA, 24'h000000
   };

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs or drops results
   initial begin : watchdog
      #15_000_000;
      $display("%0t timeout: %0d medians still expected", $time, median_queue.size());
      $display("CHECK FAILED");
      $finish;
   end

   // append to the tail of the pending pixel queue
   task automatic enqueue_pixel(input pix_type px);
      pixel_queue.insert(pixel_queue.size(), px);
   endtask

   // median of one channel over the current window, by insertion sort
   function automatic chan_type window_median(input int ch);
      chan_type sorted [WIN_N];
      chan_type v;
      int i, j, x, y;
      i = 0;
      for (y = 0; y < WIN_H; y++) begin
         for (x = 0; x < WIN_W; x++) begin
            v = win_px[y][x][ch];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = v;
            i++;
         end
      end
      return sorted[WIN_N/2];
   endfunction

   // advance the predictor by one taken pixel; queues a median for interior centres
   task automatic absorb_pixel(input pix_type px);
      int unsigned w, h, c, r;
      pix_type     fresh [WIN_H];
      median_type  m;
      int          k, x, y;
      // out-of-range sizes: width clamps to 1..MAX_W, height 0 acts as 1
      w = geo_width;
      if (w < 1) w = 1;
      if (w > MAX_W) w = MAX_W;
      h = geo_height;
      if (h < 1) h = 1;
      c = (col_pos >= MAX_W) ? 0 : col_pos;
      r = row_pos;

      // new window column: oldest row on top, this pixel at the bottom
      fresh[WIN_H-1] = px;
      for (k = 0; k < WIN_H - 1; k++) fresh[WIN_H-2-k] = line_mem[k][c];
      for (k = WIN_H - 2; k > 0; k--) line_mem[k][c] = line_mem[k-1][c];
      line_mem[0][c] = px;

      for (y = 0; y < WIN_H; y++) begin
         for (x = 0; x < WIN_W - 1; x++) win_px[y][x] = win_px[y][x+1];
         win_px[y][WIN_W-1] = fresh[y];
      end

      // only a window made entirely of this frame's pixels gives a result
      if (c >= 2 * HALF_W && r >= 2 * HALF_H) begin
         m.col   = COL_W'(c - HALF_W);
         m.row   = row_type'(r - HALF_H);
         m.blue  = window_median(CH_BLUE);
         m.green = window_median(CH_GREEN);
         m.red   = window_median(CH_RED);
         median_queue.insert(median_queue.size(), m);
      end

      // raster step, wrapping at the row end and at the frame end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t mismatch on %s: expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // pixel sender: holds an item until taken, then takes the next from the queue
   always @(posedge clock) begin : pixel_feed
      pix_type px;
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            px[CH_BLUE]  = req_if.in_blue;
            px[CH_GREEN] = req_if.in_green;
            px[CH_RED]   = req_if.in_red;
            absorb_pixel(px);
            pixels_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (feed_idle && $urandom_range(0, 9) == 0) begin
               // start a gap burst of random length
               gap_left = $urandom_range(0, 12);
               req_if.valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
               px = pixel_queue.pop_front();
               req_if.valid    <= 1'b1;
               req_if.in_blue  <= px[CH_BLUE];
               req_if.in_green <= px[CH_GREEN];
               req_if.in_red   <= px[CH_RED];
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result receiver: compares each taken item with the oldest predicted median
   always @(posedge clock) begin : median_check
      median_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            medians_seen++;
            if (median_queue.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t unexpected item: expected none actual col %0d row %0d",
                           $time, rsp_if.out_col, rsp_if.out_row);
            end else begin
               want = median_queue.pop_front();
               check_field("out_col",   16'(want.col),   16'(rsp_if.out_col));
               check_field("out_row",   want.row,        rsp_if.out_row);
               check_field("out_blue",  16'(want.blue),  16'(rsp_if.out_blue));
               check_field("out_green", 16'(want.green), 16'(rsp_if.out_green));
               check_field("out_red",   16'(want.red),   16'(rsp_if.out_red));
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (drain_idle && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // wait until nothing is queued, in flight or expected, then let the pipe run dry
   task automatic settle();
      while (pixel_queue.size() != 0 || req_if.valid || median_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; valid stays high so writes can go back to back
   task automatic write_reg(input csr_idx_type idx, input csr_data_type val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      // written at this edge; a write to a real register restarts the frame
      if (idx == CSR_IMAGE_WIDTH) geo_width = val[IMG_W_W-1:0];
      else if (idx == CSR_IMAGE_HEIGHT) geo_height = val;
      if (idx == CSR_IMAGE_WIDTH || idx == CSR_IMAGE_HEIGHT) begin
         col_pos = 0;
         row_pos = 0;
      end
      regs_written++;
   endtask

   // coarse values give many ties, including both extremes
   function automatic pix_type random_pixel(input bit coarse);
      pix_type p;
      int ch;
      for (ch = 0; ch < NUM_CH; ch++)
         p[ch] = coarse ? chan_type'($urandom_range(0, 3) * 85)
                        : chan_type'($urandom_range(0, 255));
      return p;
   endfunction

   // new frame size (width, height or both) once idle, then a run of pixels
   task automatic run_geometry(input bit set_w, input csr_data_type wv, input bit set_h,
                               input csr_data_type hv, input int count, input bit coarse);
      int i;
      settle();
      // now and then a write to an unused slot, which must leave the raster alone
      if ($urandom_range(0, 4) == 0)
         write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, csr_data_type'($urandom));
      if (set_w) write_reg(CSR_IMAGE_WIDTH, wv);
      if (set_h) write_reg(CSR_IMAGE_HEIGHT, hv);
      csr_if.valid <= 1'b0;
      for (i = 0; i < count; i++) enqueue_pixel(random_pixel(coarse));
      geometries++;
   endtask

   // random geometries: mostly small frames, some too small to filter, some wide or tall
   task automatic sweep(input int budget, input bit idling);
      int fed, w, h, weff, heff, n, mode, pick;
      fed = 0;
      while (fed < budget) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) w = $urandom_range(0, 2);
         else if (pick == 1) w = $urandom_range(13, 40);
         else w = $urandom_range(3, 12);
         pick = $urandom_range(0, 9);
         if (pick == 0) h = $urandom_range(0, 2);
         else if (pick == 1) h = $urandom_range(9, 65535);
         else h = $urandom_range(3, 8);
         weff = (w < 1) ? 1 : w;
         heff = (h < 1) ? 1 : ((h > 8) ? 8 : h);
         // one or two frames (tall ones cut to 8 rows) plus up to two rows, so a restart can land mid-frame
         n = weff * heff * $urandom_range(1, 2) + $urandom_range(0, 2 * weff);
         mode = $urandom_range(0, 3);
         feed_idle  = idling && ($urandom_range(0, 2) != 0);
         drain_idle = idling && ($urandom_range(0, 2) != 0);
         run_geometry(mode != 2, {4'($urandom_range(0, 15)), 12'(w)},
                      mode != 1, 16'(h), n, $urandom_range(0, 3) == 0);
         fed += n;
      end
   endtask

   initial begin : stimulus
      int i;
      // every input known from time zero
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.in_blue  = '0;
      req_if.in_green = '0;
      req_if.in_red   = '0;
      rsp_if.ready    = 1'b0;
      csr_if.valid    = 1'b0;
      csr_if.index    = CSR_IMAGE_WIDTH;
      csr_if.data     = '0;
      foreach (line_mem[k, c]) line_mem[k][c] = '0;
      foreach (win_px[y, x]) win_px[y][x] = '0;
      geo_width  = IMAGE_WIDTH_RST;
      geo_height = IMAGE_HEIGHT_RST;
      col_pos    = 0;
      row_pos    = 0;
      feed_idle  = 1'b1;
      drain_idle = 1'b1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // power-up size 640 by 480: corner values lead row 0, then enough rows for
      // the first medians, which take the corners into their windows
      for (i = 0; i < 20; i++) enqueue_pixel(corner_px[i]);
      for (i = 0; i < 2 * int'(IMAGE_WIDTH_RST); i++) enqueue_pixel(random_pixel(0));
      geometries++;
      settle();

      // unused register slots: nothing changes, the raster carries on in row 2
      write_reg(CSR_SPARE_A, csr_data_type'($urandom));
      write_reg(CSR_SPARE_B, csr_data_type'($urandom));
      csr_if.valid <= 1'b0;
      for (i = 0; i < 20; i++) enqueue_pixel(random_pixel(1));

      // smallest frame, with upper width bits set that the register drops
      run_geometry(1, 16'hF003, 1, 16'd3, 36, 0);
      // width 0 acts as 1, widths 1 and 2 are narrower than the window
      run_geometry(1, 16'h0000, 1, 16'd5, 15, 0);
      run_geometry(1, 16'h0001, 0, '0, 10, 0);
      run_geometry(1, 16'h0002, 1, 16'd4, 16, 1);
      // height 0 acts as 1, heights 1 and 2 are shorter than the window
      run_geometry(1, 16'h0005, 1, 16'h0000, 20, 0);
      run_geometry(0, '0, 1, 16'h0001, 20, 0);
      run_geometry(0, '0, 1, 16'h0002, 20, 1);
      // tallest frame: rows count up without wrapping
      run_geometry(1, 16'h0007, 1, 16'hFFFF, 84, 1);

      sweep(SWEEP_PIXELS, 1'b1);

      // width register all ones: upper bits dropped, clamped to the line capacity
      feed_idle  = 1'b1;
      drain_idle = 1'b1;
      run_geometry(1, 16'hFFFF, 1, 16'd3, 30, 0);

      // last stretch runs at full rate on both sides
      sweep(CALM_PIXELS, 1'b0);

      settle();
      $display("%0d pixels over %0d frame sizes, %0d register writes", pixels_taken,
               geometries, regs_written);
      $display("%0d window medians compared, %0d errors", medians_seen, errors);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
